@@ sv/ordarr_pkg.sv @@
// Shared types and codes of the ordered array block.
package ordarr_pkg;

  localparam int unsigned POS_W    = 5;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CAP_W    = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FOUND_W  = 4;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_SEARCH = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_BAD_POS   = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_EMPTY     = 3'd3,
    STATUS_NOT_FOUND = 3'd4
  } status_e;

  // Request broadcast to every cell.
  typedef struct packed {
    logic              ins;
    logic              rem;
    kind_e             kind;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
  } cmd_t;

  // Control part of the query wave that walks along the chain.
  typedef struct packed {
    logic valid;
    logic hit;
  } wave_t;

endpackage

@@ sv/ordered_array_insert_remove_search.sv @@
// Top level of the ordered array block: request decode, cell chain and result register.
//
// Usage: a request (kind_i, position_i, word_i) is taken at a rising clock edge
// where start is high and busy is low. Each request yields exactly one result
// transaction: result_valid_o is high for one cycle with status_o, read_word_o,
// found_at_o and entry_count_o, and the receiver cannot stall it.
// Insert, remove and any request rejected by its status
// checks update the chain at the accepting edge and show their result in the
// next cycle; busy stays low, so one such request can be taken every cycle.
// A valid read and every search send a query wave through the chain of
// MAX_ENTRIES cells, one cell per cycle; busy stays high until the wave has
// left the last cell, and the result is registered after that, so no new
// request is taken while a wave walks the cell chain.
// The capacity register is written through cfg_valid_i / cfg_data_i; cfg_ready_o
// is always high, and writes are meant to happen while the block is idle.
// Reset empties the list, sets the capacity to 16 and clears all handshake
// state; stored words are left as they are and are never read before written.
module ordered_array_insert_remove_search #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             kind_i,
  input  logic [ordarr_pkg::POS_W-1:0]           position_i,
  input  logic signed [ordarr_pkg::WORD_W-1:0]   word_i,
  output logic                                   result_valid_o,
  output logic [ordarr_pkg::STATUS_W-1:0]        status_o,
  output logic signed [ordarr_pkg::WORD_W-1:0]   read_word_o,
  output logic [ordarr_pkg::FOUND_W-1:0]         found_at_o,
  output logic [ordarr_pkg::COUNT_W-1:0]         entry_count_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [ordarr_pkg::CAP_W-1:0]           cfg_data_i
);

  localparam int unsigned CntW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IdxW   = $clog2(MAX_ENTRIES);
  localparam int unsigned CmpW0  = (CntW > ordarr_pkg::POS_W) ? CntW : ordarr_pkg::POS_W;
  localparam int unsigned CmpW   = (CmpW0 > ordarr_pkg::CAP_W) ? CmpW0 : ordarr_pkg::CAP_W;
  localparam int unsigned CntOW  = (CntW > ordarr_pkg::COUNT_W) ? CntW : ordarr_pkg::COUNT_W;
  localparam int unsigned FoundW = (IdxW > ordarr_pkg::FOUND_W) ? IdxW : ordarr_pkg::FOUND_W;
  localparam logic [CmpW-1:0] MaxC = CmpW'(MAX_ENTRIES);

  // One-hot controller: idle, or waiting for a query wave to leave the chain.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e                          state_q, state_d;
  logic [CntW-1:0]                 count_q, count_d;
  logic [ordarr_pkg::CAP_W-1:0]    capacity_q;
  ordarr_pkg::kind_e               req_kind_q;
  logic [ordarr_pkg::POS_W-1:0]    req_pos_q;
  logic [ordarr_pkg::WORD_W-1:0]   req_word_q;

  logic                            res_valid_q, res_valid_d;
  ordarr_pkg::status_e             res_status_q, res_status_d;
  logic [ordarr_pkg::WORD_W-1:0]   res_word_q, res_word_d;
  logic [ordarr_pkg::FOUND_W-1:0]  res_found_q, res_found_d;
  logic [CntW-1:0]                 res_count_q, res_count_d;

  logic                            accept;
  logic                            launch;
  ordarr_pkg::kind_e               in_kind;
  ordarr_pkg::cmd_t                cmd;
  logic [CmpW-1:0]                 pos_ext;
  logic [CmpW-1:0]                 cnt_ext;
  logic [CmpW-1:0]                 cap_ext;
  logic [CmpW-1:0]                 eff_cap;
  logic [FoundW-1:0]               found_ext;
  logic [CntOW-1:0]                count_out_ext;

  logic [ordarr_pkg::WORD_W-1:0]   ent       [MAX_ENTRIES];
  ordarr_pkg::wave_t               wave      [MAX_ENTRIES+1];
  logic [IdxW-1:0]                 wave_idx  [MAX_ENTRIES+1];
  logic [ordarr_pkg::WORD_W-1:0]   wave_data [MAX_ENTRIES+1];

  assign busy        = (state_q == ST_SCAN);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign in_kind     = ordarr_pkg::kind_e'(kind_i);

  // The effective capacity saturates at the number of cells.
  assign pos_ext = CmpW'(position_i);
  assign cnt_ext = CmpW'(count_q);
  assign cap_ext = CmpW'(capacity_q);
  assign eff_cap = (cap_ext > MaxC) ? MaxC : cap_ext;

  // Request decode. Rejected requests and list updates are answered at once;
  // valid reads and all searches launch a wave into the first cell.
  always_comb begin
    cmd          = '0;
    cmd.kind     = busy ? req_kind_q : in_kind;
    cmd.pos      = busy ? req_pos_q  : position_i;
    cmd.word     = busy ? req_word_q : word_i;
    launch       = 1'b0;
    count_d      = count_q;
    state_d      = state_q;
    res_valid_d  = 1'b0;
    res_status_d = ordarr_pkg::STATUS_OK;
    res_word_d   = '0;
    res_found_d  = '0;
    res_count_d  = count_q;
    found_ext    = FoundW'(wave_idx[MAX_ENTRIES]);

    if (accept) begin
      case (in_kind)
        ordarr_pkg::KIND_INSERT: begin
          if (pos_ext > cnt_ext) begin
            res_status_d = ordarr_pkg::STATUS_BAD_POS;
          end else if (cnt_ext >= eff_cap) begin
            res_status_d = ordarr_pkg::STATUS_FULL;
          end else begin
            cmd.ins = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        ordarr_pkg::KIND_REMOVE: begin
          if (count_q == '0) begin
            res_status_d = ordarr_pkg::STATUS_EMPTY;
          end else if (pos_ext >= cnt_ext) begin
            res_status_d = ordarr_pkg::STATUS_BAD_POS;
          end else begin
            cmd.rem = 1'b1;
            count_d = count_q - CntW'(1);
          end
        end
        ordarr_pkg::KIND_READ: begin
          if (count_q == '0) begin
            res_status_d = ordarr_pkg::STATUS_EMPTY;
          end else if (pos_ext >= cnt_ext) begin
            res_status_d = ordarr_pkg::STATUS_BAD_POS;
          end else begin
            launch = 1'b1;
          end
        end
        default: begin
          launch = 1'b1;
        end
      endcase
      res_valid_d = !launch;
      res_count_d = count_d;
      if (launch) begin
        state_d = ST_SCAN;
      end
    end else if (busy && wave[MAX_ENTRIES].valid) begin
      // The wave has passed every cell: report what it collected.
      state_d     = ST_IDLE;
      res_valid_d = 1'b1;
      if (req_kind_q == ordarr_pkg::KIND_READ) begin
        res_word_d = wave_data[MAX_ENTRIES];
      end else if (wave[MAX_ENTRIES].hit) begin
        res_found_d = found_ext[ordarr_pkg::FOUND_W-1:0];
      end else begin
        res_status_d = ordarr_pkg::STATUS_NOT_FOUND;
      end
    end
  end

  // Head of the wave enters the first cell.
  assign wave[0].valid = launch;
  assign wave[0].hit   = 1'b0;
  assign wave_idx[0]   = '0;
  assign wave_data[0]  = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [ordarr_pkg::WORD_W-1:0] left_word;
    logic [ordarr_pkg::WORD_W-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = ent[i];
    end else begin : g_inner_l
      assign left_word = ent[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right_word = ent[i];
    end else begin : g_inner_r
      assign right_word = ent[i+1];
    end

    ordarr_cell #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX         (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .count_i      (count_q),
      .left_word_i  (left_word),
      .right_word_i (right_word),
      .entry_o      (ent[i]),
      .wave_i       (wave[i]),
      .wave_idx_i   (wave_idx[i]),
      .wave_data_i  (wave_data[i]),
      .wave_o       (wave[i+1]),
      .wave_idx_o   (wave_idx[i+1]),
      .wave_data_o  (wave_data[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      capacity_q  <= ordarr_pkg::CAP_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q <= cfg_data_i;
      end
    end
  end

  // Request and result payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_kind_q <= in_kind;
      req_pos_q  <= position_i;
      req_word_q <= word_i;
    end
    if (res_valid_d) begin
      res_status_q <= res_status_d;
      res_word_q   <= res_word_d;
      res_found_q  <= res_found_d;
      res_count_q  <= res_count_d;
    end
  end

  assign count_out_ext  = CntOW'(res_count_q);
  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign read_word_o    = res_word_q;
  assign found_at_o     = res_found_q;
  assign entry_count_o  = count_out_ext[ordarr_pkg::COUNT_W-1:0];

  // A launched wave keeps the block busy in the following cycle.
  a_launch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch |=> busy)
    else $error("query wave launched without entering the scan state");

  // The list never holds more entries than there are cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) <= MaxC)
    else $error("entry count beyond the number of cells");

  // While a wave is in flight the list is not modified.
  a_scan_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> $stable(count_q))
    else $error("entry count changed during a scan");

  // A wave only leaves the chain while the controller waits for it.
  a_wave_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wave[MAX_ENTRIES].valid |-> busy)
    else $error("query wave left the chain outside a scan");

  // A successful insert grows the list by exactly one entry.
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not advance the entry count");

endmodule

@@ sv/ordarr_cell.sv @@
// One storage cell of the ordered array chain with its stage of the query wave.
module ordarr_cell #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned IDX         = 0
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  ordarr_pkg::cmd_t                        cmd_i,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]        count_i,
  input  logic [ordarr_pkg::WORD_W-1:0]           left_word_i,
  input  logic [ordarr_pkg::WORD_W-1:0]           right_word_i,
  output logic [ordarr_pkg::WORD_W-1:0]           entry_o,
  input  ordarr_pkg::wave_t                       wave_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]          wave_idx_i,
  input  logic [ordarr_pkg::WORD_W-1:0]           wave_data_i,
  output ordarr_pkg::wave_t                       wave_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]          wave_idx_o,
  output logic [ordarr_pkg::WORD_W-1:0]           wave_data_o
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IdxW = $clog2(MAX_ENTRIES);
  localparam int unsigned CmpW = (CntW > ordarr_pkg::POS_W) ? CntW : ordarr_pkg::POS_W;
  localparam logic [CmpW-1:0] IdxC = CmpW'(IDX);

  logic [ordarr_pkg::WORD_W-1:0] entry_q, entry_d;
  ordarr_pkg::wave_t             wave_q, wave_d;
  logic [IdxW-1:0]               wave_idx_q, wave_idx_d;
  logic [ordarr_pkg::WORD_W-1:0] wave_data_q, wave_data_d;
  logic [CmpW-1:0]               pos_ext;
  logic [CmpW-1:0]               cnt_ext;

  assign pos_ext = CmpW'(cmd_i.pos);
  assign cnt_ext = CmpW'(count_i);

  // Insert moves entries above the position up by one, remove moves them down.
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (IdxC == pos_ext) begin
        entry_d = cmd_i.word;
      end else if (IdxC > pos_ext) begin
        entry_d = left_word_i;
      end
    end else if (cmd_i.rem) begin
      if (IdxC >= pos_ext) begin
        entry_d = right_word_i;
      end
    end
  end

  // The wave keeps the first match it meets and picks up the read entry.
  always_comb begin
    wave_d      = wave_i;
    wave_idx_d  = wave_idx_i;
    wave_data_d = wave_data_i;
    if (wave_i.valid) begin
      if (cmd_i.kind == ordarr_pkg::KIND_SEARCH && !wave_i.hit && IdxC < cnt_ext &&
          entry_q == cmd_i.word) begin
        wave_d.hit = 1'b1;
        wave_idx_d = IdxW'(IDX);
      end
      if (cmd_i.kind == ordarr_pkg::KIND_READ && IdxC == pos_ext) begin
        wave_data_d = entry_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q     <= entry_d;
    wave_idx_q  <= wave_idx_d;
    wave_data_q <= wave_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else begin
      wave_q <= wave_d;
    end
  end

  assign entry_o     = entry_q;
  assign wave_o      = wave_q;
  assign wave_idx_o  = wave_idx_q;
  assign wave_data_o = wave_data_q;

endmodule
